// ----- src/ipv4_header_parser_defines.svh -----
// assertion macros shared by the ipv4 header parser modules
// no dependencies; included by files that carry concurrent assertions
`ifndef IPV4_HEADER_PARSER_DEFINES_SVH
`define IPV4_HEADER_PARSER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IHP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define IHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ihp_pkg.sv -----
// shared types, constants and helper functions of the ipv4 header parser
// no dependencies; imported by ihp_skid, ipv4_header_parser, ihp_checker and tb
package ihp_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int POS_W        = 5;
  localparam int TDATA_W      = 144;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_FIRST     = pos_t'(0);
  localparam pos_t POS_LEN_LO    = pos_t'(3);
  localparam pos_t POS_ID_LO     = pos_t'(5);
  localparam pos_t POS_FRAG_LO   = pos_t'(7);
  localparam pos_t POS_TTL       = pos_t'(8);
  localparam pos_t POS_PROTO     = pos_t'(9);
  localparam pos_t POS_SRC_FIRST = pos_t'(12);
  localparam pos_t POS_SRC_LAST  = pos_t'(15);
  localparam pos_t POS_DST_FIRST = pos_t'(16);
  localparam pos_t POS_DST_LAST  = pos_t'(19);
  localparam pos_t POS_HDR_LAST  = pos_t'(HEADER_BYTES - 1);
  localparam pos_t POS_PAYLOAD   = pos_t'(HEADER_BYTES);

  localparam logic [3:0]  IHL_FIVE   = 4'h5;
  localparam logic [15:0] CKSUM_GOOD = 16'hFFFF;
  localparam logic [7:0]  PROTO_MAX  = 8'h8E;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // first member sits in the high bits
  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  payload_byte;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
    logic [1:0]  header_status;
    logic [7:0]  protocol;
    logic [7:0]  ttl;
    logic [15:0] frag_bytes;
    logic [1:0]  frag_flags;
    logic [15:0] ident;
    logic [15:0] pkt_length;
  } out_data_t;

  typedef struct packed {
    logic      kind;
    logic      last;
    out_data_t data;
  } out_item_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic proto_known(input logic [7:0] p);
    logic known;
    known = (p <= PROTO_MAX) && !(p inside {8'h3D, 8'h3F, 8'h44, 8'h63, 8'h72, 8'h81});
    return known;
  endfunction

endpackage

// ----- src/ipv4_header_parser.sv -----
// ipv4 header parser top level: byte counter, checksum, header fields
// depends on ihp_pkg, ihp_skid and ipv4_header_parser_defines.svh
//
//  channel | ports                | contents
//  --------+----------------------+-----------------------------------------
//  input   | in_tvalid/tready     | tdata: data_byte; tlast: last byte
//  output  | out_tvalid/tready    | tdata: header record or payload byte;
//          |                      | tuser: kind; tlast: last_out
//
// one byte per cycle while in_tready is high; results are registered in the output stage
// header record is built in the cycle of byte 19 from the running checksum and field regs
// an output stall parks at most one result in the skid register and holds
// in_tready low while that skid register is full
// synchronous reset clears the byte counter and drop flag; no clearing pass
`include "ipv4_header_parser_defines.svh"

module ipv4_header_parser
  import ihp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] data_byte
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  // [15:0] pkt_length, [31:16] ident, [33:32] frag_flags, [49:34] frag_bytes,
  // [57:50] ttl, [65:58] protocol, [67:66] header_status, [99:68] src_addr,
  // [131:100] dst_addr, [139:132] payload_byte, [143:140] zero
  output logic [TDATA_W-1:0] out_tdata,
  output logic               out_tuser,  // [0] kind
  output logic               out_tlast
);

  pos_t        pos_r, pos_nxt;
  logic        dropping_r, dropping_nxt;
  logic [15:0] csum_r, csum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  logic        accept;
  logic        res_valid;
  out_item_t   res_item;
  out_item_t   m_item;
  logic [15:0] csum_base;
  logic [15:0] csum_sum;
  logic [15:0] word;

  assign accept    = in_tvalid && in_tready;
  assign word      = {hold_r, in_tdata};
  assign csum_base = (pos_r == POS_FIRST) ? 16'd0 : csum_r;
  assign csum_sum  = ones_add(csum_base, word);

  always_comb begin
    pos_nxt      = pos_r;
    dropping_nxt = dropping_r;
    csum_nxt     = csum_r;
    hold_nxt     = hold_r;
    len_nxt      = len_r;
    ident_nxt    = ident_r;
    frag_nxt     = frag_r;
    ttl_nxt      = ttl_r;
    proto_nxt    = proto_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    res_valid    = 1'b0;
    res_item     = '0;

    if (accept) begin
      if (dropping_r) begin
        if (in_tlast) begin
          dropping_nxt = 1'b0;
          pos_nxt      = POS_FIRST;
        end
      end else if (pos_r >= POS_PAYLOAD) begin
        res_valid                  = 1'b1;
        res_item.kind              = KIND_PAYLOAD;
        res_item.last              = in_tlast;
        res_item.data.payload_byte = in_tdata;
        pos_nxt                    = in_tlast ? POS_FIRST : POS_PAYLOAD;
      end else if (pos_r == POS_FIRST && in_tdata[3:0] != IHL_FIVE) begin
        csum_nxt     = 16'd0;
        dropping_nxt = !in_tlast;
        pos_nxt      = POS_FIRST;
      end else begin
        if (!pos_r[0]) begin
          hold_nxt = in_tdata;
          csum_nxt = csum_base;
        end else begin
          csum_nxt = csum_sum;
        end
        case (pos_r)
          POS_LEN_LO:  len_nxt   = word;
          POS_ID_LO:   ident_nxt = word;
          POS_FRAG_LO: frag_nxt  = word;
          POS_TTL:     ttl_nxt   = in_tdata;
          POS_PROTO:   proto_nxt = in_tdata;
          default: ;
        endcase
        if (pos_r inside {[POS_SRC_FIRST:POS_SRC_LAST]}) begin
          src_nxt = {src_r[23:0], in_tdata};
        end
        if (pos_r inside {[POS_DST_FIRST:POS_DST_LAST]}) begin
          dst_nxt = {dst_r[23:0], in_tdata};
        end

        if (pos_r == POS_HDR_LAST) begin
          res_valid                   = 1'b1;
          res_item.kind               = KIND_HEADER;
          res_item.data.pkt_length    = len_r;
          res_item.data.ident         = ident_r;
          res_item.data.frag_flags    = {frag_r[14], frag_r[13]};
          res_item.data.frag_bytes    = {frag_r[12:0], 3'b000};
          res_item.data.ttl           = ttl_r;
          res_item.data.protocol      = proto_r;
          res_item.data.header_status = {proto_known(proto_r), csum_sum == CKSUM_GOOD};
          res_item.data.src_addr      = src_r;
          res_item.data.dst_addr      = dst_nxt;
          pos_nxt                     = in_tlast ? POS_FIRST : POS_PAYLOAD;
        end else begin
          pos_nxt = in_tlast ? POS_FIRST : pos_r + pos_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_FIRST;
      dropping_r <= 1'b0;
      csum_r     <= 16'd0;
      hold_r     <= 8'd0;
      len_r      <= 16'd0;
      ident_r    <= 16'd0;
      frag_r     <= 16'd0;
      ttl_r      <= 8'd0;
      proto_r    <= 8'd0;
      src_r      <= 32'd0;
      dst_r      <= 32'd0;
    end else begin
      pos_r      <= pos_nxt;
      dropping_r <= dropping_nxt;
      csum_r     <= csum_nxt;
      hold_r     <= hold_nxt;
      len_r      <= len_nxt;
      ident_r    <= ident_nxt;
      frag_r     <= frag_nxt;
      ttl_r      <= ttl_nxt;
      proto_r    <= proto_nxt;
      src_r      <= src_nxt;
      dst_r      <= dst_nxt;
    end
  end

  ihp_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (res_valid),
    .s_ready (in_tready),
    .s_item  (res_item),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_item  (m_item)
  );

  assign out_tdata = m_item.data;
  assign out_tuser = m_item.kind;
  assign out_tlast = m_item.last;

  `IHP_ASSERT_SAME(a_drop_at_start, clk, rst_n, dropping_r, pos_r == POS_FIRST,
    "drop flag set away from packet start")
  `IHP_ASSERT_SAME(a_pos_range, clk, rst_n, 1'b1, pos_r <= POS_PAYLOAD,
    "byte counter beyond payload position")
  `IHP_ASSERT_NEXT(a_result_shown, clk, rst_n, res_valid, out_tvalid,
    "result transfer not presented on output")

endmodule

// ----- src/ihp_skid.sv -----
// two-entry output stage: result register plus skid register
// depends on ihp_pkg and ipv4_header_parser_defines.svh
`include "ipv4_header_parser_defines.svh"

module ihp_skid
  import ihp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  output logic      s_ready,
  input  out_item_t s_item,
  output logic      m_valid,
  input  logic      m_ready,
  output out_item_t m_item
);

  logic      out_valid_r;
  out_item_t out_item_r;
  logic      skid_valid_r;
  out_item_t skid_item_r;
  logic      drain;

  assign s_ready = !skid_valid_r;
  assign drain   = m_ready || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= s_valid;
      end
    end else if (s_valid && s_ready) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_item_r <= skid_valid_r ? skid_item_r : s_item;
    end else if (s_valid && s_ready) begin
      skid_item_r <= s_item;
    end
  end

  assign m_valid = out_valid_r;
  assign m_item  = out_item_r;

  `IHP_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r,
    "skid entry held while output register empty")
  `IHP_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
    s_valid && s_ready && out_valid_r && !m_ready, skid_valid_r,
    "stalled transfer not kept in skid register")
  `IHP_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && m_ready, !skid_valid_r,
    "skid register not drained")

endmodule

// ----- verif/ihp_checker.sv -----
// ipv4 header parser checker: watches both stream channels, predicts the results
// from the accepted input bytes and compares them field by field
// depends on ihp_pkg for the record layout and the byte position constants
module ihp_checker
  import ihp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,
  input  logic               out_tuser,
  input  logic               out_tlast,
  output int                 errors,
  output int                 pending
);

  pos_t        pos;
  logic        dropping;
  logic [15:0] sum_acc;
  logic [7:0]  hi_hold;
  logic [15:0] len_q;
  logic [15:0] id_q;
  logic [15:0] frag_q;
  logic [7:0]  ttl_q;
  logic [7:0]  proto_q;
  logic [31:0] src_q;
  logic [31:0] dst_q;

  out_item_t due_records[$];
  int        fail_count = 0;
  int        due_count = 0;

  assign errors  = fail_count;
  assign pending = due_count;

  function automatic logic proto_listed(input logic [7:0] p);
    if (p > PROTO_MAX) return 1'b0;
    case (p)
      8'h3D, 8'h3F, 8'h44, 8'h63, 8'h72, 8'h81: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic l,
                            output logic emit, output out_item_t rec);
    logic [15:0] word;
    logic [16:0] s;
    emit = 1'b0;
    rec  = '0;
    if (dropping) begin
      if (l) begin
        dropping = 1'b0;
        pos      = POS_FIRST;
      end
    end else if (pos >= POS_PAYLOAD) begin
      emit                  = 1'b1;
      rec.kind              = KIND_PAYLOAD;
      rec.last              = l;
      rec.data.payload_byte = b;
      pos                   = l ? POS_FIRST : POS_PAYLOAD;
    end else if (pos == POS_FIRST && b[3:0] != IHL_FIVE) begin
      // bad header length: drop up to the last byte
      dropping = !l;
    end else begin
      if (pos == POS_FIRST) sum_acc = '0;
      if (!pos[0]) begin
        hi_hold = b;
      end else begin
        word    = {hi_hold, b};
        s       = {1'b0, sum_acc} + {1'b0, word};
        sum_acc = s[15:0] + {15'd0, s[16]};
        case (pos)
          POS_LEN_LO:  len_q  = word;
          POS_ID_LO:   id_q   = word;
          POS_FRAG_LO: frag_q = word;
          default: ;
        endcase
      end
      if (pos == POS_TTL) ttl_q = b;
      if (pos == POS_PROTO) proto_q = b;
      if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) src_q = {src_q[23:0], b};
      if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) dst_q = {dst_q[23:0], b};
      if (pos == POS_HDR_LAST) begin
        emit                   = 1'b1;
        rec.kind               = KIND_HEADER;
        rec.data.pkt_length    = len_q;
        rec.data.ident         = id_q;
        rec.data.frag_flags    = frag_q[14:13];
        rec.data.frag_bytes    = {frag_q[12:0], 3'b000};
        rec.data.ttl           = ttl_q;
        rec.data.protocol      = proto_q;
        rec.data.header_status = {proto_listed(proto_q), sum_acc == CKSUM_GOOD};
        rec.data.src_addr      = src_q;
        rec.data.dst_addr      = dst_q;
        pos                    = l ? POS_FIRST : POS_PAYLOAD;
      end else begin
        pos = l ? POS_FIRST : pos + pos_t'(1);
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    $display("ihp_checker: %s got %h want %h", what, got, want);
  endtask

  task automatic compare(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  always @(posedge clk) begin : watch
    logic       emit;
    out_item_t  rec;
    out_item_t  want;
    out_data_t  got;
    if (!rst_n) begin
      pos      = POS_FIRST;
      dropping = 1'b0;
      sum_acc  = '0;
      hi_hold  = '0;
      len_q    = '0;
      id_q     = '0;
      frag_q   = '0;
      ttl_q    = '0;
      proto_q  = '0;
      src_q    = '0;
      dst_q    = '0;
      due_records.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_data_t'(out_tdata);
        if (due_records.size() == 0) begin
          report("transfer with nothing expected", {31'd0, out_tuser}, 32'd0);
        end else begin
          want = due_records.pop_front();
          compare("kind", {31'd0, out_tuser}, {31'd0, want.kind});
          compare("last_out", {31'd0, out_tlast}, {31'd0, want.last});
          compare("pkt_length", {16'd0, got.pkt_length}, {16'd0, want.data.pkt_length});
          compare("ident", {16'd0, got.ident}, {16'd0, want.data.ident});
          compare("frag_flags", {30'd0, got.frag_flags}, {30'd0, want.data.frag_flags});
          compare("frag_bytes", {16'd0, got.frag_bytes}, {16'd0, want.data.frag_bytes});
          compare("ttl", {24'd0, got.ttl}, {24'd0, want.data.ttl});
          compare("protocol", {24'd0, got.protocol}, {24'd0, want.data.protocol});
          compare("header_status", {30'd0, got.header_status},
                  {30'd0, want.data.header_status});
          compare("src_addr", got.src_addr, want.data.src_addr);
          compare("dst_addr", got.dst_addr, want.data.dst_addr);
          compare("payload_byte", {24'd0, got.payload_byte}, {24'd0, want.data.payload_byte});
          compare("pad", {28'd0, got.pad}, 32'd0);
        end
      end
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tlast, emit, rec);
        if (emit) due_records.push_back(rec);
      end
    end
    due_count <= due_records.size();
  end

endmodule

// ----- verif/tb.sv -----
// testbench top for the ipv4 header parser: clock, reset, packet stimulus and verdict
// depends on ihp_pkg, ipv4_header_parser and ihp_checker
module tb;
  import ihp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_GOAL   = 1100;
  localparam int CALM_TAIL   = 150;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic [7:0]         in_tdata = 8'h00;
  logic               in_tlast = 1'b0;
  logic               out_tready = 1'b0;
  wire                in_tready;
  wire                out_tvalid;
  wire [TDATA_W-1:0]  out_tdata;
  wire                out_tuser;
  wire                out_tlast;

  int          errors;
  int          pending;
  int          cycles = 0;
  int          sent = 0;
  int          stall_left = 0;
  logic        send_idle = 1'b0;
  logic        take_idle = 1'b0;
  logic [7:0]  pkt[$];

  always #2 clk = ~clk;

  ipv4_header_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  ihp_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver stalls in random bursts while take_idle is set
  always @(posedge clk) begin
    if (!rst_n || !take_idle) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (send_idle && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  function automatic logic [7:0] pick_protocol();
    logic [7:0] p;
    p = 8'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 8))
        0: p = 8'h00;
        1: p = 8'h3D;
        2: p = 8'h3F;
        3: p = 8'h44;
        4: p = 8'h63;
        5: p = 8'h72;
        6: p = 8'h81;
        7: p = PROTO_MAX;
        default: p = PROTO_MAX + 8'h01;
      endcase
    end
    return p;
  endfunction

  // twenty header bytes with a valid length nibble and a computed or corrupted checksum
  task automatic make_header(input logic [7:0] fill, input logic rnd, input logic corrupt);
    logic [31:0] acc;
    logic [15:0] ck;
    pkt.delete();
    for (int i = 0; i < HEADER_BYTES; i++) pkt.push_back(rnd ? 8'($urandom) : fill);
    pkt[0] = {pkt[0][7:4], IHL_FIVE};
    if (rnd) pkt[9] = pick_protocol();
    pkt[10] = 8'h00;
    pkt[11] = 8'h00;
    acc = 0;
    for (int i = 0; i < HEADER_BYTES; i += 2) acc += {16'd0, pkt[i], pkt[i+1]};
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    ck = ~acc[15:0];
    if (corrupt) ck ^= 16'(1) << $urandom_range(0, 15);
    pkt[10] = ck[15:8];
    pkt[11] = ck[7:0];
  endtask

  initial begin : stimulus
    int         shape;
    int         n;
    logic [7:0] b;
    logic       drained;
    drained = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // all-ones header, protocol at the top of the known range, header only
    make_header(8'hFF, 1'b0, 1'b0);
    pkt[9] = PROTO_MAX;
    send_packet();
    // bad length nibble on a lone last byte, then on a short run
    pkt.delete();
    pkt.push_back(8'h00);
    send_packet();
    pkt.delete();
    pkt.push_back(8'h46);
    pkt.push_back(8'h45);
    pkt.push_back(8'h05);
    send_packet();

    while (sent < BYTE_GOAL) begin
      if (sent > BYTE_GOAL - CALM_TAIL) begin
        send_idle = 1'b0;
        take_idle = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        send_idle = $urandom_range(0, 2) != 0;
        take_idle = $urandom_range(0, 2) != 0;
      end
      shape = $urandom_range(0, 99);
      if (shape < 80) begin
        make_header(8'h00, 1'b1, shape >= 70);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        repeat (n) pkt.push_back(8'($urandom));
      end else if (shape < 88) begin
        make_header(8'h00, 1'b1, 1'b0);
        n = $urandom_range(1, HEADER_BYTES - 1);
        while (pkt.size() > n) pkt.delete(pkt.size() - 1);
      end else if (shape < 96) begin
        pkt.delete();
        do b = 8'($urandom); while (b[3:0] == IHL_FIVE);
        pkt.push_back(b);
        repeat ($urandom_range(0, 7)) pkt.push_back(8'($urandom));
      end else begin
        pkt.delete();
        repeat ($urandom_range(1, 25)) pkt.push_back(8'($urandom));
      end
      send_packet();
      if (!drained && sent >= BYTE_GOAL / 2) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
